// ----- hw/rtl/wbed_pkg.sv -----
// shared constants and types for the weighted bin energy deposit block
`timescale 1ns / 1ps
`default_nettype none
package wbed_pkg;
	localparam int unsigned DefNumBins = 256;
	localparam int unsigned PosW = 32;
	localparam int unsigned EnW = 32;
	localparam int unsigned SumW = 48;
	localparam int unsigned CfgW = 9;
	localparam int unsigned RdW = 8;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

	typedef enum logic {
		MODE_DEPOSIT = 1'b0,
		MODE_READ    = 1'b1
	} mode_t;
endpackage
`default_nettype wire

// ----- hw/rtl/wbed_if.sv -----
// valid/ready channel interfaces for items and results and configuration
`timescale 1ns / 1ps
`default_nettype none
interface wbed_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] start_position;
	logic [31:0] end_position;
	logic [31:0] total_deposit;
	logic [31:0] nonionizing_deposit;
	logic [31:0] track_weight;
	logic [7:0]  read_bin;
	modport source (output valid, mode, start_position, end_position, total_deposit,
		nonionizing_deposit, track_weight, read_bin, input ready);
	modport sink (input valid, mode, start_position, end_position, total_deposit,
		nonionizing_deposit, track_weight, read_bin, output ready);
endinterface

interface wbed_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] total_sum;
	logic [47:0] ionizing_sum;
	logic [8:0]  bins_touched;
	logic        step_rejected;
	modport source (output valid, total_sum, ionizing_sum, bins_touched, step_rejected,
		input ready);
	modport sink (input valid, total_sum, ionizing_sum, bins_touched, step_rejected,
		output ready);
endinterface

interface wbed_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/wbed_ram.sv -----
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module wbed_ram #(
	parameter int unsigned Width = 48,
	parameter int unsigned Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/wbed_front.sv -----
// front: classifies items, weights energies, orders span ends
`timescale 1ns / 1ps
`default_nettype none
module wbed_front
	import wbed_pkg::*;
#(
	parameter int unsigned NumBins = DefNumBins
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	wbed_in_if.sink          in_ch,
	input  wire logic [8:0]  active_bins,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output logic             cmd_mode,
	output logic             cmd_rej,
	output logic [7:0]       cmd_rbin,
	output logic signed [32:0] cmd_lo,
	output logic signed [32:0] cmd_hi,
	output logic [47:0]      cmd_et,
	output logic [47:0]      cmd_ei
);
	// two stage: s1 capture, s2 multiply and shift
	logic busy_q, s2_q;
	logic mode_q, rej_q;
	logic [7:0] rbin_q;
	logic signed [32:0] lo_q, hi_q;
	logic [31:0] tot_q, ion_q, w_q;
	logic [63:0] pt_q, pi_q;
	logic [12:0] nb;
	logic signed [33:0] limit;
	logic signed [33:0] sx, ex;
	logic s_in, e_in;

	always_comb begin
		if (active_bins == 9'd0) nb = 13'd1;
		else if ({4'd0, active_bins} > 13'(NumBins)) nb = 13'(NumBins);
		else nb = {4'd0, active_bins};
		limit = {5'd0, nb, 16'd0};
		sx = 34'(signed'(in_ch.start_position));
		ex = 34'(signed'(in_ch.end_position));
		s_in = (sx >= 0) && (sx < limit);
		e_in = (ex >= 0) && (ex < limit);
	end

	assign in_ch.ready = !busy_q;
	assign cmd_valid = busy_q && s2_q;
	assign cmd_mode = mode_q;
	assign cmd_rej = rej_q;
	assign cmd_rbin = rbin_q;
	assign cmd_lo = lo_q;
	assign cmd_hi = hi_q;
	assign cmd_et = pt_q[63:16];
	assign cmd_ei = pi_q[63:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			s2_q <= 1'b0;
		end else if (!busy_q) begin
			if (in_ch.valid) begin
				busy_q <= 1'b1;
				s2_q <= 1'b0;
			end
		end else if (!s2_q) begin
			s2_q <= 1'b1;
		end else if (cmd_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_ch.valid) begin
			mode_q <= in_ch.mode;
			rej_q <= !s_in && !e_in;
			rbin_q <= in_ch.read_bin;
			lo_q <= (sx < ex) ? sx[32:0] : ex[32:0];
			hi_q <= (sx < ex) ? ex[32:0] : sx[32:0];
			tot_q <= in_ch.total_deposit;
			ion_q <= (in_ch.total_deposit > in_ch.nonionizing_deposit) ?
				in_ch.total_deposit - in_ch.nonionizing_deposit : 32'd0;
			w_q <= in_ch.track_weight;
		end
		if (busy_q && !s2_q) begin
			pt_q <= 64'(tot_q) * 64'(w_q);
			pi_q <= 64'(ion_q) * 64'(w_q);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/wbed_back.sv -----
// back: bin walk, two serial dividers in lockstep, read-modify-write of both tables
`timescale 1ns / 1ps
`default_nettype none
module wbed_back
	import wbed_pkg::*;
#(
	parameter int unsigned NumBins = DefNumBins
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [8:0]  active_bins,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  wire logic        cmd_mode,
	input  wire logic        cmd_rej,
	input  wire logic [7:0]  cmd_rbin,
	input  wire logic signed [32:0] cmd_lo,
	input  wire logic signed [32:0] cmd_hi,
	input  wire logic [47:0] cmd_et,
	input  wire logic [47:0] cmd_ei,
	wbed_out_if.source       out_ch
);
	localparam int unsigned AW = $clog2(NumBins);
	localparam int unsigned KW = AW + 2;
	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_NEXT, ST_MUL, ST_DIV, ST_RD, ST_RDW, ST_WR,
		ST_RBACK, ST_RBW, ST_OUT
	} st_t;
	st_t st_q;

	logic [AW-1:0] clr_q;
	logic mode_q;
	logic [7:0] rbin_q;
	logic signed [32:0] lo_q, hi_q;
	logic [47:0] et_q, ei_q;
	logic [32:0] span_q, ov_q;
	logic signed [KW-1:0] k_q, last_q;
	logic [8:0] touched_q;
	logic [79:0] pt_q, pi_q;
	logic [79:0] qt_q, qi_q;
	logic [32:0] rt_q, ri_q;
	logic [6:0] dcnt_q;
	logic [47:0] add_t_q, add_i_q;
	logic mph_q;

	// ram ports
	logic we;
	logic [AW-1:0] addr;
	logic [47:0] wt, wi, rt, ri;

	wbed_ram #(.Width(SumW), .Depth(NumBins)) u_tot (
		.clk(clk), .we(we), .addr(addr), .wdata(wt), .rdata(rt));
	wbed_ram #(.Width(SumW), .Depth(NumBins)) u_ion (
		.clk(clk), .we(we), .addr(addr), .wdata(wi), .rdata(ri));

	// effective bin count
	logic [12:0] nb;
	always_comb begin
		if (active_bins == 9'd0) nb = 13'd1;
		else if ({4'd0, active_bins} > 13'(NumBins)) nb = 13'(NumBins);
		else nb = {4'd0, active_bins};
	end

	// bin overlap of current k
	logic signed [33:0] blo, bhi, top, bot;
	always_comb begin
		blo = 34'(k_q) <<< 16;
		bhi = blo + 34'sd65536;
		top = (34'(hi_q) < bhi) ? 34'(hi_q) : bhi;
		bot = (34'(lo_q) > blo) ? 34'(lo_q) : blo;
	end

	// energy times overlap in two halves; overlap never exceeds one bin (17 bits)
	logic [23:0] mop_t, mop_i;
	logic [40:0] mp_t, mp_i;
	always_comb begin
		mop_t = mph_q ? et_q[47:24] : et_q[23:0];
		mop_i = mph_q ? ei_q[47:24] : ei_q[23:0];
		mp_t = mop_t * ov_q[16:0];
		mp_i = mop_i * ov_q[16:0];
	end

	// restoring divider step
	logic [33:0] tt, ti;
	always_comb begin
		tt = {rt_q, qt_q[79]} - {1'b0, span_q};
		ti = {ri_q, qi_q[79]} - {1'b0, span_q};
	end

	logic [48:0] st_sum, si_sum;
	always_comb begin
		st_sum = 49'(rt) + 49'(add_t_q);
		si_sum = 49'(ri) + 49'(add_i_q);
		wt = (st_q == ST_CLEAR) ? '0 : (st_sum[48] ? SumMax : st_sum[47:0]);
		wi = (st_q == ST_CLEAR) ? '0 : (si_sum[48] ? SumMax : si_sum[47:0]);
		we = (st_q == ST_CLEAR) || (st_q == ST_WR);
		case (st_q)
			ST_CLEAR: addr = clr_q;
			ST_RBACK, ST_RBW: addr = AW'(rbin_q);
			default: addr = k_q[AW-1:0];
		endcase
	end

	assign cmd_ready = (st_q == ST_IDLE);
	assign out_ch.valid = (st_q == ST_OUT);

	logic signed [33:0] fb_lo, fb_hi;
	assign fb_lo = 34'(cmd_lo) >>> 16;
	assign fb_hi = 34'(cmd_hi) >>> 16;

	function automatic logic fb_ok();
		logic signed [33:0] b;
		b = 34'(lo_q) >>> 16;
		return (b >= 0) && (b < 34'(nb));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			mph_q <= 1'b0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NumBins - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						mode_q <= cmd_mode;
						rbin_q <= cmd_rbin;
						lo_q <= cmd_lo;
						hi_q <= cmd_hi;
						et_q <= cmd_et;
						ei_q <= cmd_ei;
						span_q <= 33'(cmd_hi - cmd_lo);
						touched_q <= '0;
						out_ch.total_sum <= '0;
						out_ch.ionizing_sum <= '0;
						out_ch.step_rejected <= (cmd_mode == MODE_DEPOSIT) && cmd_rej;
						k_q <= (fb_lo < 0) ? '0 : KW'(fb_lo);
						last_q <= (fb_hi > 34'(nb) - 1) ? KW'(nb - 1) : KW'(fb_hi);
						if (cmd_mode == MODE_READ) begin
							st_q <= ({24'd0, cmd_rbin} < 32'(NumBins)) ? ST_RBACK : ST_OUT;
						end else if (cmd_rej) begin
							st_q <= ST_OUT;
						end else begin
							st_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					if (span_q == 0) begin
						// zero-length step: whole amount to one bin
						add_t_q <= et_q;
						add_i_q <= ei_q;
						if (fb_ok()) begin
							k_q <= KW'(34'(lo_q) >>> 16);
							st_q <= ST_RD;
						end else st_q <= ST_OUT;
						last_q <= KW'(34'(lo_q) >>> 16);
					end else if (k_q > last_q) begin
						st_q <= ST_OUT;
					end else if (top > bot) begin
						ov_q <= 33'(top - bot);
						mph_q <= 1'b0;
						st_q <= ST_MUL;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (!mph_q) begin
						pt_q <= 80'(mp_t);
						pi_q <= 80'(mp_i);
						mph_q <= 1'b1;
					end else begin
						pt_q <= pt_q + {15'd0, mp_t, 24'd0};
						pi_q <= pi_q + {15'd0, mp_i, 24'd0};
						st_q <= ST_DIV;
						dcnt_q <= '0;
						rt_q <= '0;
						ri_q <= '0;
					end
				end
				ST_DIV: begin
					if (dcnt_q == 7'd0) begin
						qt_q <= pt_q;
						qi_q <= pi_q;
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q != 7'd0) begin
						if (!tt[33]) begin
							rt_q <= tt[32:0];
							qt_q <= {qt_q[78:0], 1'b1};
						end else begin
							rt_q <= {rt_q[31:0], qt_q[79]};
							qt_q <= {qt_q[78:0], 1'b0};
						end
						if (!ti[33]) begin
							ri_q <= ti[32:0];
							qi_q <= {qi_q[78:0], 1'b1};
						end else begin
							ri_q <= {ri_q[31:0], qi_q[79]};
							qi_q <= {qi_q[78:0], 1'b0};
						end
					end
					if (dcnt_q == 7'd80) st_q <= ST_RD;
				end
				ST_RD: begin
					if (span_q != 0) begin
						add_t_q <= qt_q[47:0];
						add_i_q <= qi_q[47:0];
					end
					st_q <= ST_RDW;
				end
				ST_RDW: st_q <= ST_WR;
				ST_WR: begin
					touched_q <= touched_q + 1'b1;
					k_q <= k_q + 1'b1;
					st_q <= (span_q == 0) ? ST_OUT : ST_NEXT;
				end
				ST_RBACK: st_q <= ST_RBW;
				ST_RBW: begin
					out_ch.total_sum <= rt;
					out_ch.ionizing_sum <= ri;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ch.ready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.bins_touched = (mode_q == MODE_DEPOSIT) ? touched_q : 9'd0;
endmodule
`default_nettype wire

// ----- hw/rtl/weighted_bin_energy_deposit.sv -----
// top level of the weighted bin energy deposit block
//
// channel  dir  carries
// in_ch    in   mode, step ends, energies, weight, read bin
// out_ch   out  two bin sums, bins touched, reject flag
// cfg_ch   in   active_bins register
//
// front takes a transaction, forms weighted energies in its multiply stage, holds it for the back
// back per touched bin: overlap step, two-half multiply, serial divide, read-modify-write
// a read goes through RBACK and RBW to OUT, a rejected step straight to OUT, zero length via rmw
// after reset both tables are cleared before the back takes commands
// either side stalls on its own ready
`timescale 1ns / 1ps
`default_nettype none
module weighted_bin_energy_deposit
	import wbed_pkg::*;
#(
	parameter int unsigned NUM_BINS = DefNumBins
) (
	input wire logic clk,
	input wire logic arst_n,
	wbed_in_if.sink  in_ch,
	wbed_out_if.source out_ch,
	wbed_cfg_if.sink cfg_ch
);
	// configuration register
	logic [8:0] active_bins_q;
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) active_bins_q <= 9'd256;
		else if (cfg_ch.valid) active_bins_q <= cfg_ch.data;
	end

	// command hand-off between front and back
	logic cmd_valid, cmd_ready, cmd_mode, cmd_rej;
	logic [7:0] cmd_rbin;
	logic signed [32:0] cmd_lo, cmd_hi;
	logic [47:0] cmd_et, cmd_ei;

	wbed_front #(.NumBins(NUM_BINS)) u_front (
		.clk, .arst_n, .in_ch, .active_bins(active_bins_q),
		.cmd_valid, .cmd_ready, .cmd_mode, .cmd_rej, .cmd_rbin,
		.cmd_lo, .cmd_hi, .cmd_et, .cmd_ei);

	wbed_back #(.NumBins(NUM_BINS)) u_back (
		.clk, .arst_n, .active_bins(active_bins_q),
		.cmd_valid, .cmd_ready, .cmd_mode, .cmd_rej, .cmd_rbin,
		.cmd_lo, .cmd_hi, .cmd_et, .cmd_ei, .out_ch);

	// a rejected step never reports touched bins
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.step_rejected |-> out_ch.bins_touched == 9'd0)
		else $error("rejected step touched bins");
	// results hold while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.total_sum))
		else $error("result changed under stall");
endmodule
`default_nettype wire
